[rtl/pva_pkg.sv]
// Shared types, field widths and command codes of the voice allocator.
// Used by the channel interfaces, the core and pva_slot_eval; depends on nothing.
package pva_pkg;

  localparam int STREAM_W = 64;
  localparam int NOTE_W   = 64;
  localparam int PITCH_W  = 7;
  localparam int VEL_W    = 7;
  localparam int BEND_W   = 17;
  localparam int AGE_W    = 32;
  localparam int REL_W    = 24;
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  // Bends are accepted within plus or minus 128.27 semitones in 1/256 steps.
  localparam logic signed [BEND_W-1:0] BEND_LIMIT    = 17'sd32837;
  localparam logic [REL_W-1:0]         RELEASE_RESET = 24'd24000;
  localparam logic [AGE_W-1:0]         AGE_MAX       = '1;
  localparam logic [REL_W-1:0]         REL_AGE_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON  = 2'd0,
    CMD_NOTE_OFF = 2'd1,
    CMD_BEND     = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [STREAM_W-1:0]      stream;
    logic [NOTE_W-1:0]        note;
    logic [PITCH_W-1:0]       pitch;
    logic [VEL_W-1:0]         velocity;
    logic signed [BEND_W-1:0] bend;
  } slot_data_t;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [REL_W-1:0] rel_age;
  } slot_time_t;

  typedef struct packed {
    logic       stream_match;
    logic       id_match;
    logic       expired;
    slot_time_t time_nxt;
  } slot_eval_t;

  function automatic logic bend_in_range(logic signed [BEND_W-1:0] b);
    return (b >= -BEND_LIMIT) && (b <= BEND_LIMIT);
  endfunction

endpackage

[rtl/pva_if.sv]
// Valid/ready channel interfaces of the voice allocator: request, result, configuration.
// Depends on pva_pkg for the field widths.
interface pva_in_if;
  logic                               valid;
  logic                               ready;
  logic [pva_pkg::CMD_W-1:0]          cmd;
  logic [pva_pkg::STREAM_W-1:0]       stream_id;
  logic [pva_pkg::NOTE_W-1:0]         note_id;
  logic [pva_pkg::PITCH_W-1:0]        pitch;
  logic [pva_pkg::VEL_W-1:0]          velocity;
  logic signed [pva_pkg::BEND_W-1:0]  bend;

  modport source (output valid, cmd, stream_id, note_id, pitch, velocity, bend, input ready);
  modport sink   (input valid, cmd, stream_id, note_id, pitch, velocity, bend, output ready);
endinterface

interface pva_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [pva_pkg::SLOT_W-1:0]    voice_slot;
  logic                          stole;
  logic [pva_pkg::COUNT_W-1:0]   voices_ended;
  logic [pva_pkg::COUNT_W-1:0]   active_count;

  modport source (output valid, ok, voice_slot, stole, voices_ended, active_count, input ready);
  modport sink   (input valid, ok, voice_slot, stole, voices_ended, active_count, output ready);
endinterface

interface pva_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pva_pkg::REL_W-1:0]   release_frames;

  modport source (output valid, release_frames, input ready);
  modport sink   (input valid, release_frames, output ready);
endinterface

[rtl/polyphonic_voice_allocator_core.sv]
// Top level of the polyphonic voice allocator with oldest-voice stealing.
// Depends on pva_pkg, pva_if (channel interfaces), pva_ram and pva_slot_eval.
// Usage:
//   in_chan carries one command request (note on, note off, pitch bend, frame tick).
//   out_chan returns exactly one result request per command, in order.
//   cfg_chan writes release_frames; it is always ready and must only be used
//   while no command is in flight.
// Timing:
//   Every command makes one pass over the slot pool, reading one slot per cycle
//   from the slot memories (registered read port). A new request is accepted
//   only once the previous command has gone through its scan, write and
//   completion states and the allocator is back in its idle state.
// Reset:
//   rst_n (synchronous, active low) frees all voices, clears the active count
//   and sets release_frames to 24000. The slot memories need no clearing since
//   a slot's contents are only used while it is marked active.
// Stalls:
//   The result sits in an output register. The next request is accepted while
//   that result waits; a finished pass then holds until the register frees up.
module polyphonic_voice_allocator_core #(
  parameter int VOICE_COUNT = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  pva_in_if.sink        in_chan,
  pva_out_if.source     out_chan,
  pva_cfg_if.sink       cfg_chan
);
  import pva_pkg::*;

  localparam int IDX_W  = $clog2(VOICE_COUNT);
  localparam int ISS_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(VOICE_COUNT + 1);
  localparam int DATA_W = $bits(slot_data_t);
  localparam int TIME_W = $bits(slot_time_t);
  localparam logic [ISS_W-1:0] ISSUE_END = ISS_W'(VOICE_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(VOICE_COUNT - 1);

  // ---------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------
  logic [REL_W-1:0] release_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_r <= RELEASE_RESET;
    end else if (cfg_chan.valid) begin
      release_r <= cfg_chan.release_frames;
    end
  end

  // ---------------------------------------------------------------------------
  // Captured request. The parameter checks that need no slot state are done
  // once at accept time and kept in req_ok_r.
  // ---------------------------------------------------------------------------
  cmd_t                     req_cmd_r;
  logic [STREAM_W-1:0]      req_sid_r;
  logic [NOTE_W-1:0]        req_nid_r;
  logic [PITCH_W-1:0]       req_pitch_r;
  logic [VEL_W-1:0]         req_vel_r;
  logic signed [BEND_W-1:0] req_bend_r;
  logic                     req_ok_r;
  logic                     req_ok_nxt;
  logic                     in_acc;

  state_t state_r, state_nxt;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);

  always_comb begin
    case (cmd_t'(in_chan.cmd))
      CMD_NOTE_ON: begin
        req_ok_nxt = (in_chan.stream_id != '0) && (in_chan.note_id != '0) &&
                     (in_chan.velocity != '0) && bend_in_range(in_chan.bend);
      end
      CMD_NOTE_OFF: req_ok_nxt = (in_chan.stream_id != '0) && (in_chan.note_id != '0);
      CMD_BEND:     req_ok_nxt = (in_chan.stream_id != '0) && bend_in_range(in_chan.bend);
      CMD_TICK:     req_ok_nxt = 1'b1;
      default:      req_ok_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_cmd_r   <= cmd_t'(in_chan.cmd);
      req_sid_r   <= in_chan.stream_id;
      req_nid_r   <= in_chan.note_id;
      req_pitch_r <= in_chan.pitch;
      req_vel_r   <= in_chan.velocity;
      req_bend_r  <= in_chan.bend;
      req_ok_r    <= req_ok_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot memories: identity and sound parameters in one, the two ages in the
  // other. Reads are issued one slot per cycle during the scan; a slot is
  // written back in the cycle after its read, while the next slot is read,
  // so the same entry is never read and written in one cycle.
  // ---------------------------------------------------------------------------
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [IDX_W-1:0]  mem_waddr;
  logic              dat_we, tim_we;
  slot_data_t        dat_wdata, dat_q;
  slot_time_t        tim_wdata, tim_q;
  logic [DATA_W-1:0] dat_rdata;
  logic [TIME_W-1:0] tim_rdata;

  pva_ram #(.WIDTH(DATA_W), .DEPTH(VOICE_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (mem_waddr),
    .wdata (DATA_W'(dat_wdata)),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (dat_rdata)
  );

  pva_ram #(.WIDTH(TIME_W), .DEPTH(VOICE_COUNT)) u_time_ram (
    .clk   (clk),
    .we    (tim_we),
    .waddr (mem_waddr),
    .wdata (TIME_W'(tim_wdata)),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (tim_rdata)
  );

  assign dat_q = slot_data_t'(dat_rdata);
  assign tim_q = slot_time_t'(tim_rdata);

  // ---------------------------------------------------------------------------
  // Scan state. Active and released flags live in flip-flops so that reset
  // frees the whole pool at once.
  // ---------------------------------------------------------------------------
  logic [ISS_W-1:0]       issue_r, issue_nxt;
  logic                   proc_vld_r, proc_vld_nxt;
  logic [IDX_W-1:0]       proc_idx_r, proc_idx_nxt;
  logic [VOICE_COUNT-1:0] act_r, act_nxt;
  logic [VOICE_COUNT-1:0] rel_r, rel_nxt;
  logic [CNT_W-1:0]       active_cnt_r, active_cnt_nxt;
  logic                   dup_r, dup_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [IDX_W-1:0]       free_idx_r, free_idx_nxt;
  logic                   old_have_r, old_have_nxt;
  logic [IDX_W-1:0]       old_idx_r, old_idx_nxt;
  logic [AGE_W-1:0]       old_age_r, old_age_nxt;
  logic                   off_done_r, off_done_nxt;
  logic [CNT_W-1:0]       ended_r, ended_nxt;
  logic                   out_vld_r, out_vld_nxt;
  logic                   out_load;

  slot_eval_t ev;

  pva_slot_eval u_eval (
    .data_i           (dat_q),
    .time_i           (tim_q),
    .rel_i            (rel_r[proc_idx_r]),
    .sid_i            (req_sid_r),
    .nid_i            (req_nid_r),
    .release_frames_i (release_r),
    .eval_o           (ev)
  );

  // Outcome of a note on, valid once the scan is over.
  logic                on_ok;
  logic [IDX_W-1:0]    pick;
  logic                pick_stole;
  logic                res_ok;
  logic [IDX_W+SLOT_W-1:0]   slot_wide;
  logic [CNT_W+COUNT_W-1:0]  ended_wide;
  logic [CNT_W+COUNT_W-1:0]  count_wide;
  logic                is_on;

  assign is_on      = (req_cmd_r == CMD_NOTE_ON);
  assign on_ok      = req_ok_r && !dup_r;
  // A free slot wins; with the pool full the oldest voice is stolen.
  assign pick       = free_found_r ? free_idx_r : old_idx_r;
  assign pick_stole = !free_found_r;
  assign res_ok     = is_on ? on_ok : req_ok_r;
  assign slot_wide  = (is_on && on_ok) ? {{SLOT_W{1'b0}}, pick} : '0;
  assign ended_wide = {{COUNT_W{1'b0}}, ended_r};
  assign count_wide = {{COUNT_W{1'b0}}, active_cnt_r};

  always_comb begin
    state_nxt      = state_r;
    issue_nxt      = issue_r;
    proc_vld_nxt   = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    act_nxt        = act_r;
    rel_nxt        = rel_r;
    active_cnt_nxt = active_cnt_r;
    dup_nxt        = dup_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    old_have_nxt   = old_have_r;
    old_idx_nxt    = old_idx_r;
    old_age_nxt    = old_age_r;
    off_done_nxt   = off_done_r;
    ended_nxt      = ended_r;
    out_vld_nxt    = out_vld_r && !out_chan.ready;
    out_load       = 1'b0;

    mem_re    = 1'b0;
    mem_raddr = issue_r[IDX_W-1:0];
    mem_waddr = proc_idx_r;
    dat_we    = 1'b0;
    tim_we    = 1'b0;
    dat_wdata = dat_q;
    tim_wdata = ev.time_nxt;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt      = ST_SCAN;
          issue_nxt      = '0;
          dup_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          old_have_nxt   = 1'b0;
          off_done_nxt   = 1'b0;
          ended_nxt      = '0;
        end
      end

      ST_SCAN: begin
        if (issue_r != ISSUE_END) begin
          mem_re       = 1'b1;
          issue_nxt    = issue_r + ISS_W'(1);
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = issue_r[IDX_W-1:0];
        end
        if (proc_vld_r) begin
          case (req_cmd_r)
            CMD_NOTE_ON: begin
              if (act_r[proc_idx_r] && ev.id_match) begin
                dup_nxt = 1'b1;
              end
              if (!act_r[proc_idx_r]) begin
                if (!free_found_r) begin
                  free_found_nxt = 1'b1;
                  free_idx_nxt   = proc_idx_r;
                end
              end else if (!old_have_r || (tim_q.age > old_age_r)) begin
                // Strictly greater keeps the lowest index on a tie.
                old_have_nxt = 1'b1;
                old_idx_nxt  = proc_idx_r;
                old_age_nxt  = tim_q.age;
              end
            end
            CMD_NOTE_OFF: begin
              if (req_ok_r && act_r[proc_idx_r] && ev.id_match &&
                  !rel_r[proc_idx_r] && !off_done_r) begin
                rel_nxt[proc_idx_r] = 1'b1;
                off_done_nxt        = 1'b1;
              end
            end
            CMD_BEND: begin
              if (req_ok_r && act_r[proc_idx_r] && ev.stream_match) begin
                dat_we         = 1'b1;
                dat_wdata.bend = req_bend_r;
              end
            end
            CMD_TICK: begin
              if (act_r[proc_idx_r]) begin
                if (ev.expired) begin
                  act_nxt[proc_idx_r] = 1'b0;
                  rel_nxt[proc_idx_r] = 1'b0;
                  ended_nxt           = ended_r + CNT_W'(1);
                  active_cnt_nxt      = active_cnt_r - CNT_W'(1);
                end else begin
                  tim_we = 1'b1;
                end
              end
            end
            default: ;
          endcase
          if (proc_idx_r == IDX_LAST) begin
            state_nxt = ST_WRITE;
          end
        end
      end

      ST_WRITE: begin
        // An accepted note on claims its slot here, after the whole pool was seen.
        if (is_on && on_ok) begin
          mem_waddr = pick;
          dat_we    = 1'b1;
          tim_we    = 1'b1;
          dat_wdata = '{stream: req_sid_r, note: req_nid_r, pitch: req_pitch_r,
                        velocity: req_vel_r, bend: req_bend_r};
          tim_wdata = '0;
          act_nxt[pick] = 1'b1;
          rel_nxt[pick] = 1'b0;
          if (!pick_stole) begin
            active_cnt_nxt = active_cnt_r + CNT_W'(1);
          end
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_r      <= '0;
      proc_vld_r   <= 1'b0;
      act_r        <= '0;
      rel_r        <= '0;
      active_cnt_r <= '0;
      dup_r        <= 1'b0;
      free_found_r <= 1'b0;
      old_have_r   <= 1'b0;
      off_done_r   <= 1'b0;
      ended_r      <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_r      <= issue_nxt;
      proc_vld_r   <= proc_vld_nxt;
      act_r        <= act_nxt;
      rel_r        <= rel_nxt;
      active_cnt_r <= active_cnt_nxt;
      dup_r        <= dup_nxt;
      free_found_r <= free_found_nxt;
      old_have_r   <= old_have_nxt;
      off_done_r   <= off_done_nxt;
      ended_r      <= ended_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx_r <= proc_idx_nxt;
    free_idx_r <= free_idx_nxt;
    old_idx_r  <= old_idx_nxt;
    old_age_r  <= old_age_nxt;
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic               out_ok_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_stole_r;
  logic [COUNT_W-1:0] out_ended_r;
  logic [COUNT_W-1:0] out_count_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r    <= res_ok;
      out_slot_r  <= slot_wide[SLOT_W-1:0];
      out_stole_r <= is_on && on_ok && pick_stole;
      out_ended_r <= ended_wide[COUNT_W-1:0];
      out_count_r <= count_wide[COUNT_W-1:0];
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.ok           = out_ok_r;
  assign out_chan.voice_slot   = out_slot_r;
  assign out_chan.stole        = out_stole_r;
  assign out_chan.voices_ended = out_ended_r;
  assign out_chan.active_count = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The running count of active voices agrees with the flags between commands.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (active_cnt_r == CNT_W'($countones(act_r))))
    else $error("active voice count disagrees with slot flags");

  // Only an active voice can be in its release phase.
  a_rel_needs_act: assert property (@(posedge clk) disable iff (!rst_n)
    ((rel_r & ~act_r) == '0))
    else $error("released flag set on a free slot");

  // A result appears only at the end of a pass.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_DONE))
    else $error("result presented outside the completion state");

endmodule

[rtl/pva_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/pva_slot_eval.sv]
// Per-slot evaluation for one scan step: identity matches, release expiry and aged times.
// Depends on pva_pkg.
module pva_slot_eval (
  input  pva_pkg::slot_data_t                data_i,
  input  pva_pkg::slot_time_t                time_i,
  input  logic                               rel_i,
  input  logic [pva_pkg::STREAM_W-1:0]       sid_i,
  input  logic [pva_pkg::NOTE_W-1:0]         nid_i,
  input  logic [pva_pkg::REL_W-1:0]          release_frames_i,
  output pva_pkg::slot_eval_t                eval_o
);
  import pva_pkg::*;

  always_comb begin
    eval_o.stream_match = (data_i.stream == sid_i);
    eval_o.id_match     = (data_i.stream == sid_i) && (data_i.note == nid_i);
    eval_o.expired      = rel_i && (time_i.rel_age >= release_frames_i);
    // Both ages saturate at the top of their range.
    eval_o.time_nxt.age = (time_i.age != AGE_MAX) ? time_i.age + AGE_W'(1) : time_i.age;
    if (rel_i && (time_i.rel_age != REL_AGE_MAX)) begin
      eval_o.time_nxt.rel_age = time_i.rel_age + REL_W'(1);
    end else begin
      eval_o.time_nxt.rel_age = time_i.rel_age;
    end
  end

endmodule
